@@ src/inms_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// inms_pkg
// Shared widths, register indexes and line-buffer word layout for the
// interpolated non-maximum suppression block.
// ----------------------------------------------------------------------------
package inms_pkg;

   localparam int MAX_WIDTH  = 1024;
   localparam int GRAD_BITS  = 12;
   localparam int MAG_BITS   = 16;
   localparam int ADDR_BITS  = $clog2(MAX_WIDTH);
   localparam int ROW_BITS   = 12;
   localparam int WREG_BITS  = 11;
   localparam int MAX_HEIGHT = 4095;

   // Interpolation weight (sum or difference of two gradients) and products.
   localparam int Q_BITS     = GRAD_BITS + 2;
   localparam int PT_BITS    = GRAD_BITS + MAG_BITS + 1;
   localparam int PQ_BITS    = Q_BITS + MAG_BITS + 1;
   localparam int SUM_BITS   = PQ_BITS + 1;

   // Line buffer word: upper magnitude, middle magnitude, middle gx, middle gy.
   localparam int LB_BITS    = 2 * MAG_BITS + 2 * GRAD_BITS;

   localparam int CSR_ADDR_BITS = 3;

   typedef enum logic {
      REG_IMAGE_WIDTH  = 1'b0,
      REG_IMAGE_HEIGHT = 1'b1
   } reg_index_type;

endpackage : inms_pkg
`default_nettype wire

@@ src/interpolated_nonmax_suppression.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// interpolated_nonmax_suppression
// Canny non-maximum suppression with gradient-interpolated neighbors.
// ----------------------------------------------------------------------------
// The block takes one gradient request per clock in raster order and returns,
// for every interior pixel, the kept magnitude or zero with the pixel's column
// and row; border pixels produce no result. Throughput is one request per
// cycle whenever the result side is ready. The line-buffer read happens at the
// accepting edge, and the window update, operand selection, the multiplier
// stage, the add and absolute-value stage and the output register follow in
// that order. All line buffers share one RAM word per column, read for a
// column when its request is accepted and written back when that request
// moves on to the window stage. Consecutive requests always touch different
// columns, so no forwarding is needed. The image size is set over the APB
// port (width at byte 0, height at byte 4) and should only change while no
// request is in flight; out-of-range sizes are clamped.
module interpolated_nonmax_suppression
   import inms_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   // Requests: grad_x [11:0], grad_y [23:12], mag_in [39:24].
   input  wire logic                     req_tvalid,
   output logic                          req_tready,
   input  wire logic [39:0]              req_tdata,
   // Results: nms_value [15:0], out_col [25:16], out_row [37:26], zero fill.
   output logic                          rsp_tvalid,
   input  wire logic                     rsp_tready,
   output logic      [39:0]              rsp_tdata,
   output logic                          rsp_tlast,
   // Configuration port.
   input  wire logic                     csr_psel,
   input  wire logic                     csr_penable,
   input  wire logic                     csr_pwrite,
   input  wire logic [CSR_ADDR_BITS-1:0] csr_paddr,
   input  wire logic [31:0]              csr_pwdata,
   output logic      [31:0]              csr_prdata,
   output logic                          csr_pready
);

   // ----------------------------------------------------------------------
   // Configuration registers.
   // ----------------------------------------------------------------------
   logic [WREG_BITS-1:0] image_width_ff;
   logic [ROW_BITS-1:0]  image_height_ff;
   logic                 csr_write;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         image_width_ff  <= WREG_BITS'(640);
         image_height_ff <= ROW_BITS'(480);
      end else if (csr_write) begin
         unique case (reg_index_type'(csr_paddr[2]))
            REG_IMAGE_WIDTH:  image_width_ff  <= csr_pwdata[WREG_BITS-1:0];
            REG_IMAGE_HEIGHT: image_height_ff <= csr_pwdata[ROW_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_index_type'(csr_paddr[2]))
         REG_IMAGE_WIDTH:  csr_prdata = {{(32-WREG_BITS){1'b0}}, image_width_ff};
         REG_IMAGE_HEIGHT: csr_prdata = {{(32-ROW_BITS){1'b0}}, image_height_ff};
         default:          csr_prdata = '0;
      endcase
   end

   // Clamp the size registers to the supported ranges.
   logic [WREG_BITS-1:0] width_used;
   logic [ROW_BITS-1:0]  height_used;

   always_comb begin
      width_used = image_width_ff;
      if (image_width_ff < WREG_BITS'(3)) width_used = WREG_BITS'(3);
      if (image_width_ff > WREG_BITS'(MAX_WIDTH)) width_used = WREG_BITS'(MAX_WIDTH);
      height_used = image_height_ff;
      if (image_height_ff < ROW_BITS'(3)) height_used = ROW_BITS'(3);
      if (image_height_ff > ROW_BITS'(MAX_HEIGHT)) height_used = ROW_BITS'(MAX_HEIGHT);
   end

   // ----------------------------------------------------------------------
   // Flow control: the whole pipeline advances together whenever the output
   // register is empty or being drained.
   // ----------------------------------------------------------------------
   logic advance;
   logic req_accept;

   assign advance    = !rsp_tvalid || rsp_tready;
   assign req_tready = advance;
   assign req_accept = req_tvalid && advance;

   logic signed [GRAD_BITS-1:0] req_gx;
   logic signed [GRAD_BITS-1:0] req_gy;
   logic        [MAG_BITS-1:0]  req_mag;

   assign req_gx  = req_tdata[GRAD_BITS-1:0];
   assign req_gy  = req_tdata[2*GRAD_BITS-1:GRAD_BITS];
   assign req_mag = req_tdata[2*GRAD_BITS+MAG_BITS-1:2*GRAD_BITS];

   // ----------------------------------------------------------------------
   // Raster counters and the interior test, evaluated at acceptance.
   // ----------------------------------------------------------------------
   logic [ADDR_BITS-1:0] col_count_ff, col_count_in;
   logic [ROW_BITS-1:0]  row_count_ff, row_count_in;
   logic [ADDR_BITS:0]   col_next;
   logic [ROW_BITS:0]    row_next;
   logic                 emit;
   logic                 last;

   always_comb begin
      col_next = {1'b0, col_count_ff} + 1'b1;
      row_next = {1'b0, row_count_ff} + 1'b1;
      emit = ({1'b0, col_count_ff} >= (ADDR_BITS+1)'(2)) &&
             ({1'b0, col_count_ff} <  (ADDR_BITS+1)'(width_used)) &&
             (row_count_ff >= ROW_BITS'(2)) && (row_count_ff < height_used);
      last = (col_next == (ADDR_BITS+1)'(width_used)) &&
             (row_next == {1'b0, height_used});
      col_count_in = col_count_ff;
      row_count_in = row_count_ff;
      if (req_accept) begin
         if (col_next >= (ADDR_BITS+1)'(width_used)) begin
            col_count_in = '0;
            row_count_in = (row_next >= {1'b0, height_used}) ? '0 :
                           row_next[ROW_BITS-1:0];
         end else begin
            col_count_in = col_next[ADDR_BITS-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_count_ff <= '0;
         row_count_ff <= '0;
      end else begin
         col_count_ff <= col_count_in;
         row_count_ff <= row_count_in;
      end
   end

   // ----------------------------------------------------------------------
   // Stage 1: request held while the line-buffer word is read.
   // ----------------------------------------------------------------------
   logic                        s1_valid_ff;
   logic [ADDR_BITS-1:0]        s1_col_ff;
   logic signed [GRAD_BITS-1:0] s1_gx_ff, s1_gy_ff;
   logic [MAG_BITS-1:0]         s1_mag_ff;
   logic                        s1_emit_ff, s1_last_ff;
   logic [ADDR_BITS-1:0]        s1_out_col_ff;
   logic [ROW_BITS-1:0]         s1_out_row_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= req_tvalid;
      end
      if (req_accept) begin
         s1_col_ff     <= col_count_ff;
         s1_gx_ff      <= req_gx;
         s1_gy_ff      <= req_gy;
         s1_mag_ff     <= req_mag;
         s1_emit_ff    <= emit;
         s1_last_ff    <= last;
         s1_out_col_ff <= col_count_ff - 1'b1;
         s1_out_row_ff <= row_count_ff - 1'b1;
      end
   end

   logic               lb_we;
   logic [LB_BITS-1:0] lb_wdata;
   logic [LB_BITS-1:0] lb_rdata;
   logic [MAG_BITS-1:0] rd_upper, rd_middle;
   logic signed [GRAD_BITS-1:0] rd_gx, rd_gy;

   assign rd_upper  = lb_rdata[MAG_BITS-1:0];
   assign rd_middle = lb_rdata[2*MAG_BITS-1:MAG_BITS];
   assign rd_gx     = lb_rdata[2*MAG_BITS+GRAD_BITS-1:2*MAG_BITS];
   assign rd_gy     = lb_rdata[LB_BITS-1:2*MAG_BITS+GRAD_BITS];

   // The middle row moves up and the new request becomes the middle row.
   assign lb_we    = advance && s1_valid_ff;
   assign lb_wdata = {s1_gy_ff, s1_gx_ff, s1_mag_ff, rd_middle};

   inms_ram #(
      .WIDTH (LB_BITS),
      .DEPTH (MAX_WIDTH)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (lb_we),
      .wr_addr (s1_col_ff),
      .wr_data (lb_wdata),
      .rd_en   (advance),
      .rd_addr (col_count_ff),
      .rd_data (lb_rdata)
   );

   // ----------------------------------------------------------------------
   // Stage 2: window shift and the delayed centre gradient.
   // ----------------------------------------------------------------------
   logic [MAG_BITS-1:0]         win_ff [3][3];
   logic signed [GRAD_BITS-1:0] centre_gx_ff, centre_gy_ff;
   logic                        k2_valid_ff, k2_last_ff;
   logic signed [GRAD_BITS-1:0] k2_gx_ff, k2_gy_ff;
   logic [ADDR_BITS-1:0]        k2_col_ff;
   logic [ROW_BITS-1:0]         k2_row_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
               win_ff[i][j] <= '0;
            end
         end
         centre_gx_ff <= '0;
         centre_gy_ff <= '0;
         k2_valid_ff  <= 1'b0;
      end else if (advance) begin
         k2_valid_ff <= s1_valid_ff && s1_emit_ff;
         if (s1_valid_ff) begin
            for (int i = 0; i < 3; i++) begin
               win_ff[i][0] <= win_ff[i][1];
               win_ff[i][1] <= win_ff[i][2];
            end
            win_ff[0][2] <= rd_upper;
            win_ff[1][2] <= rd_middle;
            win_ff[2][2] <= s1_mag_ff;
            centre_gx_ff <= rd_gx;
            centre_gy_ff <= rd_gy;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance && s1_valid_ff) begin
         k2_gx_ff   <= centre_gx_ff;
         k2_gy_ff   <= centre_gy_ff;
         k2_col_ff  <= s1_out_col_ff;
         k2_row_ff  <= s1_out_row_ff;
         k2_last_ff <= s1_last_ff;
      end
   end

   // ----------------------------------------------------------------------
   // Stage 3: direction case and multiplier operands. The window still holds
   // this pixel's neighborhood because every stage advances together.
   // ----------------------------------------------------------------------
   logic signed [Q_BITS-1:0]   sgx, sgy, abs_x, abs_y, w_sum, w_dif;
   logic                       opposite, xdom;
   logic signed [Q_BITS-1:0]   op_d, op_p, op_q;
   logic [MAG_BITS-1:0]        op_a1, op_a2, op_b1, op_b2;

   always_comb begin
      sgx   = Q_BITS'(k2_gx_ff);
      sgy   = Q_BITS'(k2_gy_ff);
      abs_x = k2_gx_ff[GRAD_BITS-1] ? -sgx : sgx;
      abs_y = k2_gy_ff[GRAD_BITS-1] ? -sgy : sgy;
      xdom  = abs_x >= abs_y;
      w_sum = sgx + sgy;
      w_dif = sgx - sgy;
      opposite = (k2_gx_ff == '0) || (k2_gy_ff == '0) ||
                 (k2_gx_ff[GRAD_BITS-1] != k2_gy_ff[GRAD_BITS-1]);
      op_d = xdom ? sgx : sgy;
      op_p = xdom ? sgy : sgx;
      if (opposite) begin
         // Gradient points into the NE/SW quadrants.
         op_q  = -w_sum;
         op_a1 = win_ff[0][2];
         op_b1 = win_ff[2][0];
         op_a2 = xdom ? win_ff[1][2] : win_ff[0][1];
         op_b2 = xdom ? win_ff[1][0] : win_ff[2][1];
      end else begin
         // Gradient points into the SE/NW quadrants.
         op_q  = xdom ? w_dif : -w_dif;
         op_a1 = win_ff[2][2];
         op_b1 = win_ff[0][0];
         op_a2 = xdom ? win_ff[1][2] : win_ff[2][1];
         op_b2 = xdom ? win_ff[1][0] : win_ff[0][1];
      end
   end

   logic                       k3_valid_ff, k3_last_ff;
   logic signed [Q_BITS-1:0]   k3_d_ff, k3_p_ff, k3_q_ff;
   logic [MAG_BITS-1:0]        k3_c_ff, k3_a1_ff, k3_a2_ff, k3_b1_ff, k3_b2_ff;
   logic [ADDR_BITS-1:0]       k3_col_ff;
   logic [ROW_BITS-1:0]        k3_row_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         k3_valid_ff <= 1'b0;
      end else if (advance) begin
         k3_valid_ff <= k2_valid_ff;
      end
      if (advance) begin
         k3_d_ff    <= op_d;
         k3_p_ff    <= op_p;
         k3_q_ff    <= op_q;
         k3_c_ff    <= win_ff[1][1];
         k3_a1_ff   <= op_a1;
         k3_a2_ff   <= op_a2;
         k3_b1_ff   <= op_b1;
         k3_b2_ff   <= op_b2;
         k3_col_ff  <= k2_col_ff;
         k3_row_ff  <= k2_row_ff;
         k3_last_ff <= k2_last_ff;
      end
   end

   // ----------------------------------------------------------------------
   // Stage 4: the five products.
   // ----------------------------------------------------------------------
   logic signed [PQ_BITS-1:0] prod_t, prod_a1, prod_a2, prod_b1, prod_b2;

   always_comb begin
      prod_t  = PQ_BITS'(k3_d_ff) * PQ_BITS'($signed({1'b0, k3_c_ff}));
      prod_a1 = PQ_BITS'(k3_p_ff) * PQ_BITS'($signed({1'b0, k3_a1_ff}));
      prod_a2 = PQ_BITS'(k3_q_ff) * PQ_BITS'($signed({1'b0, k3_a2_ff}));
      prod_b1 = PQ_BITS'(k3_p_ff) * PQ_BITS'($signed({1'b0, k3_b1_ff}));
      prod_b2 = PQ_BITS'(k3_q_ff) * PQ_BITS'($signed({1'b0, k3_b2_ff}));
   end

   logic                      k4_valid_ff, k4_last_ff;
   logic signed [PQ_BITS-1:0] k4_t_ff, k4_a1_ff, k4_a2_ff, k4_b1_ff, k4_b2_ff;
   logic [MAG_BITS-1:0]       k4_c_ff;
   logic [ADDR_BITS-1:0]      k4_col_ff;
   logic [ROW_BITS-1:0]       k4_row_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         k4_valid_ff <= 1'b0;
      end else if (advance) begin
         k4_valid_ff <= k3_valid_ff;
      end
      if (advance) begin
         k4_t_ff    <= prod_t;
         k4_a1_ff   <= prod_a1;
         k4_a2_ff   <= prod_a2;
         k4_b1_ff   <= prod_b1;
         k4_b2_ff   <= prod_b2;
         k4_c_ff    <= k3_c_ff;
         k4_col_ff  <= k3_col_ff;
         k4_row_ff  <= k3_row_ff;
         k4_last_ff <= k3_last_ff;
      end
   end

   // ----------------------------------------------------------------------
   // Stage 5: interpolated neighbors and absolute values.
   // ----------------------------------------------------------------------
   logic signed [SUM_BITS-1:0] sum_a, sum_b, ext_t;
   logic [SUM_BITS-1:0]        abs_t, abs_a, abs_b;

   always_comb begin
      sum_a = SUM_BITS'(k4_a1_ff) + SUM_BITS'(k4_a2_ff);
      sum_b = SUM_BITS'(k4_b1_ff) + SUM_BITS'(k4_b2_ff);
      ext_t = SUM_BITS'(k4_t_ff);
      abs_t = ext_t[SUM_BITS-1] ? SUM_BITS'(-ext_t) : SUM_BITS'(ext_t);
      abs_a = sum_a[SUM_BITS-1] ? SUM_BITS'(-sum_a) : SUM_BITS'(sum_a);
      abs_b = sum_b[SUM_BITS-1] ? SUM_BITS'(-sum_b) : SUM_BITS'(sum_b);
   end

   logic                 k5_valid_ff, k5_last_ff;
   logic [SUM_BITS-1:0]  k5_t_ff, k5_a_ff, k5_b_ff;
   logic [MAG_BITS-1:0]  k5_c_ff;
   logic [ADDR_BITS-1:0] k5_col_ff;
   logic [ROW_BITS-1:0]  k5_row_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         k5_valid_ff <= 1'b0;
      end else if (advance) begin
         k5_valid_ff <= k4_valid_ff;
      end
      if (advance) begin
         k5_t_ff    <= abs_t;
         k5_a_ff    <= abs_a;
         k5_b_ff    <= abs_b;
         k5_c_ff    <= k4_c_ff;
         k5_col_ff  <= k4_col_ff;
         k5_row_ff  <= k4_row_ff;
         k5_last_ff <= k4_last_ff;
      end
   end

   // ----------------------------------------------------------------------
   // Output register: the centre survives only if it is no smaller than neighbor A and larger than neighbor B.
   // ----------------------------------------------------------------------
   logic                 keep;
   logic                 rsp_valid_ff, rsp_last_ff;
   logic [MAG_BITS-1:0]  rsp_value_ff;
   logic [ADDR_BITS-1:0] rsp_col_ff;
   logic [ROW_BITS-1:0]  rsp_row_ff;

   assign keep = (k5_t_ff >= k5_a_ff) && (k5_t_ff > k5_b_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= k5_valid_ff;
      end
      if (advance) begin
         rsp_value_ff <= keep ? k5_c_ff : '0;
         rsp_col_ff   <= k5_col_ff;
         rsp_row_ff   <= k5_row_ff;
         rsp_last_ff  <= k5_last_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {{(40-MAG_BITS-ADDR_BITS-ROW_BITS){1'b0}},
                        rsp_row_ff, rsp_col_ff, rsp_value_ff};

`ifndef SYNTH
   // The write-back of one column never collides with the read of the next.
   a_no_ram_collision: assert property (@(posedge clock) disable iff (reset)
      lb_we |-> s1_col_ff != col_count_ff)
      else $error("line buffer read and write hit the same column");

   // A stalled pipeline leaves the raster position untouched.
   a_counter_hold: assert property (@(posedge clock) disable iff (reset)
      !req_tready |=> $stable(col_count_ff) && $stable(row_count_ff))
      else $error("raster counters moved during a stall");

   // Results never name a pixel of the first row or the first column.
   a_interior: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_col_ff != '0 && rsp_row_ff != '0)
      else $error("result for a border pixel");

   // The window only moves when a request leaves the line-buffer stage.
   a_window_hold: assert property (@(posedge clock) disable iff (reset)
      !(advance && s1_valid_ff) |=> $stable(win_ff[1][1]))
      else $error("window shifted without a request");
`endif

endmodule : interpolated_nonmax_suppression
`default_nettype wire

@@ src/inms_ram.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// inms_ram
// Generic simple dual-port RAM: one write port, one read port with a
// registered read that holds while the read enable is low.
// ----------------------------------------------------------------------------
module inms_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule : inms_ram
`default_nettype wire
